FILE: rtl/gregorian_date_normalize_macros.svh
// assertion macros for the date normalizer checker
`ifndef GREGORIAN_DATE_NORMALIZE_MACROS_SVH
`define GREGORIAN_DATE_NORMALIZE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define GDN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date normalizer check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define GDN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date normalizer check failed");

`endif

FILE: rtl/gdn_pkg.sv
package gdn_pkg;

  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
  localparam logic [9:0] YEAR_CYCLE = 10'd400;
  localparam logic [8:0] CENTURY_1 = 9'd100;
  localparam logic [8:0] CENTURY_2 = 9'd200;
  localparam logic [8:0] CENTURY_3 = 9'd300;
  localparam logic [8:0] CYCLE_LAST = 9'd399;

  // ceil(2^17 / 25), exact quotient for dividends up to 2048
  localparam logic [23:0] RECIP_25 = 24'd5243;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MONTH = 2'd1;
  localparam logic [1:0] STAT_YEAR  = 2'd2;

  localparam logic [4:0] MONTH_LEN [MONTHS_PER_YEAR] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic signed [15:0] year_in;
    logic        [3:0]  month_in;
    logic signed [15:0] day_in;
    logic signed [15:0] offset;
  } in_t;

  typedef struct packed {
    logic signed [15:0] year_out;
    logic        [3:0]  month_out;
    logic        [4:0]  day_out;
    logic        [1:0]  status;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESID,
    S_STEP,
    S_DONE
  } state_t;

  // leap test on the year residue mod 400
  function automatic logic is_leap(logic [8:0] r);
    is_leap = (r[1:0] == 2'b00) && (r != CENTURY_1) && (r != CENTURY_2) &&
              (r != CENTURY_3);
  endfunction

  // month length for month 1..12
  function automatic logic [4:0] month_days(logic [3:0] m, logic lp);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m == MONTH_FEB && lp) begin
      month_days = FEB_LEAP_DAYS;
    end else begin
      month_days = MONTH_LEN[idx];
    end
  endfunction

endpackage

FILE: rtl/gregorian_date_normalize.sv
// Adds a signed day offset to a Gregorian date and walks month by month until
// the day falls inside its month, carrying the year at December and borrowing it
// at January (proleptic Gregorian leap years). One item is in flight at a time:
// after acceptance the year residue mod 400 is formed by a reciprocal multiply,
// then a single adder moves the day by one month length per cycle until it fits,
// crossing up to about 2155 months, and the result is registered once the
// previous result has been taken on out_ready. An invalid month (0 or 13..15)
// goes straight to the done state with no stepping and is registered with status 1
// once the output is free. Status 2 marks a final year outside the 16-bit range;
// year_out then holds its low 16 bits. in_ready is high only while the block is
// idle, which it becomes as the result is registered; the finished result sits in
// an output register.
module gregorian_date_normalize (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gdn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gdn_pkg::out_t out_data
);
  import gdn_pkg::*;

  state_t             state_r, state_nxt;
  logic signed [16:0] y_r, y_nxt;
  logic [3:0]         m_r, m_nxt;
  logic signed [17:0] d_r, d_nxt;
  logic [8:0]         r_r, r_nxt;
  logic               bad_r, bad_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               accept;
  logic               month_bad;
  logic               rem_start;
  logic               rem_done;
  logic [8:0]         rem_residue;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign month_bad = (in_data.month_in == 4'd0) || (in_data.month_in > MONTH_DEC);
  assign rem_start = accept && !month_bad;

  gdn_rem400 u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rem_start),
    .year    (in_data.year_in),
    .done    (rem_done),
    .residue (rem_residue)
  );

  // neighbor months and their lengths
  logic               wrap_back, wrap_fwd;
  logic [3:0]         pm, nm;
  logic [8:0]         pr, nr;
  logic [4:0]         cur_len, prev_len;
  logic               go_back, go_fwd;
  logic signed [17:0] addend;

  always_comb begin
    wrap_back = (m_r == MONTH_JAN);
    wrap_fwd  = (m_r == MONTH_DEC);
    pm        = wrap_back ? MONTH_DEC : m_r - 4'd1;
    nm        = wrap_fwd ? MONTH_JAN : m_r + 4'd1;
    pr        = wrap_back ? ((r_r == 9'd0) ? CYCLE_LAST : r_r - 9'd1) : r_r;
    nr        = wrap_fwd ? ((r_r == CYCLE_LAST) ? 9'd0 : r_r + 9'd1) : r_r;
    cur_len   = month_days(m_r, is_leap(r_r));
    prev_len  = month_days(pm, is_leap(pr));
    go_back   = d_r[17] || (d_r == 18'sd0);
    go_fwd    = d_r > $signed({13'd0, cur_len});
    addend    = go_back ? $signed({13'd0, prev_len}) : -$signed({13'd0, cur_len});
  end

  // sequencer and datapath
  always_comb begin
    state_nxt     = state_r;
    y_nxt         = y_r;
    m_nxt         = m_r;
    d_nxt         = d_r;
    r_nxt         = r_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          y_nxt   = 17'(in_data.year_in);
          m_nxt   = in_data.month_in;
          d_nxt   = 18'(in_data.day_in) + 18'(in_data.offset);
          bad_nxt = month_bad;
          state_nxt = month_bad ? S_DONE : S_RESID;
        end
      end
      S_RESID: begin
        if (rem_done) begin
          r_nxt     = rem_residue;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (go_back) begin
          m_nxt = pm;
          r_nxt = pr;
          y_nxt = wrap_back ? y_r - 17'sd1 : y_r;
          d_nxt = d_r + addend;
        end else if (go_fwd) begin
          m_nxt = nm;
          r_nxt = nr;
          y_nxt = wrap_fwd ? y_r + 17'sd1 : y_r;
          d_nxt = d_r + addend;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.year_out  = y_r[15:0];
          out_data_nxt.month_out = m_r;
          if (bad_r) begin
            out_data_nxt.day_out = 5'd0;
            out_data_nxt.status  = STAT_MONTH;
          end else begin
            out_data_nxt.day_out = d_r[4:0];
            out_data_nxt.status  = (y_r[16] != y_r[15]) ? STAT_YEAR : STAT_OK;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    y_r        <= y_nxt;
    m_r        <= m_nxt;
    d_r        <= d_nxt;
    r_r        <= r_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/gdn_rem400.sv
module gdn_rem400 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] year,
  output logic               done,
  output logic [8:0]         residue
);
  import gdn_pkg::*;

  logic        v1_r, v1_nxt;
  logic        v2_r, v2_nxt;
  logic        done_r, done_nxt;
  logic [15:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  quo_r, quo_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [23:0] prod;
  logic [15:0] back;
  logic [15:0] diff;

  // magnitude on start, quotient by reciprocal next cycle, remainder after that
  always_comb begin
    v1_nxt   = start;
    v2_nxt   = v1_r;
    done_nxt = v2_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    // |y| / 400 is (|y| >> 4) / 25
    prod     = {12'd0, mag_r[15:4]} * RECIP_25;
    quo_nxt  = prod[23:17];
    back     = {9'd0, quo_r} * {6'd0, YEAR_CYCLE};
    diff     = mag_r - back;
    rem_nxt  = diff[8:0];
    if (start) begin
      neg_nxt = year[15];
      mag_nxt = year[15] ? 16'(-year) : 16'(year);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
      done_r <= done_nxt;
    end
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  // negative years fold into 0..399
  logic [9:0] folded;
  assign folded  = YEAR_CYCLE - {1'b0, rem_r};
  assign done    = done_r;
  assign residue = (neg_r && rem_r != 9'd0) ? folded[8:0] : rem_r;

endmodule

FILE: rtl/gdn_checker.sv
`include "gregorian_date_normalize_macros.svh"

module gdn_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input gdn_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input gdn_pkg::out_t out_data
);
  import gdn_pkg::*;

  // a stalled result holds
  `GDN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // one item at a time: busy right after a transfer in
  `GDN_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

  // a bad month accepted while the output is free is reported via the done state
  `GDN_ASSERT_IMP(a_bad_month,
    in_valid && in_ready && (in_data.month_in == 4'd0 || in_data.month_in > MONTH_DEC) &&
    (!out_valid || out_ready),
    ##2 (out_valid && out_data.status == STAT_MONTH))

endmodule

bind gregorian_date_normalize gdn_checker u_gdn_checker (.*);
